// ===== src/yrr_pkg.sv =====
package yrr_pkg;

    localparam int MAX_DIM_DEF = 4096;
    localparam int QDEPTH      = 4;
    localparam int TERM_W      = 18;

    // register map, byte address is 4 * index
    localparam logic [2:0] REG_FRAME_WIDTH    = 3'd0;
    localparam logic [2:0] REG_FRAME_HEIGHT   = 3'd1;
    localparam logic [2:0] REG_DEST_ROW_BYTES = 3'd2;
    localparam logic [2:0] REG_ROTATION_MODE  = 3'd3;
    localparam logic [2:0] REG_MIRROR_ENABLE  = 3'd4;

    localparam logic [1:0] ROT_0   = 2'd0;
    localparam logic [1:0] ROT_90  = 2'd1;
    localparam logic [1:0] ROT_180 = 2'd2;
    localparam logic [1:0] ROT_270 = 2'd3;

    typedef struct packed {
        logic [11:0] block_col;
        logic [11:0] block_row;
        logic [7:0]  luma_top_left;
        logic [7:0]  luma_top_right;
        logic [7:0]  luma_bottom_left;
        logic [7:0]  luma_bottom_right;
        logic [7:0]  chroma_u;
        logic [7:0]  chroma_v;
    } t_blk_in;

    typedef struct packed {
        logic [27:0] dest_offset;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic        last_pixel;
    } t_pix_out;

    // clamped dimensions and placement controls
    typedef struct packed {
        logic [12:0] eff_w;
        logic [12:0] eff_h;
        logic [15:0] dest_row_bytes;
        logic [1:0]  rotation_mode;
        logic        mirror_enable;
    } t_cfg;

    // classified block waiting for the pixel engine
    typedef struct packed {
        logic [11:0]              col;
        logic [11:0]              row;
        logic [3:0][7:0]          luma;
        logic signed [TERM_W-1:0] r_term;
        logic signed [TERM_W-1:0] g_term;
        logic signed [TERM_W-1:0] b_term;
        logic [3:0]               mask;
    } t_blk;

endpackage

// ===== src/yrr_front.sv =====
module yrr_front import yrr_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_blk_in i_in_data,
    output logic    o_push,
    output t_blk    o_entry,
    input  logic    i_full
);

    logic                     r_valid;
    t_blk                     r_entry;
    t_blk                     n_entry;
    logic signed [TERM_W-1:0] d;
    logic signed [TERM_W-1:0] e;
    logic [11:0]              sx;
    logic [11:0]              sy;
    logic                     free;

    always_comb begin
        d = 18'($signed({1'b0, i_in_data.chroma_u})) - 18'sd128;
        e = 18'($signed({1'b0, i_in_data.chroma_v})) - 18'sd128;
        n_entry.col     = {i_in_data.block_col[11:1], 1'b0};
        n_entry.row     = {i_in_data.block_row[11:1], 1'b0};
        n_entry.luma[0] = i_in_data.luma_top_left;
        n_entry.luma[1] = i_in_data.luma_top_right;
        n_entry.luma[2] = i_in_data.luma_bottom_left;
        n_entry.luma[3] = i_in_data.luma_bottom_right;
        n_entry.r_term  = 18'sd409 * e + 18'sd128;
        n_entry.g_term  = 18'sd128 - 18'sd100 * d - 18'sd208 * e;
        n_entry.b_term  = 18'sd516 * d + 18'sd128;
        for (int k = 0; k < 4; k++) begin
            sx = {i_in_data.block_col[11:1], 1'(k & 1)};
            sy = {i_in_data.block_row[11:1], 1'(k >> 1)};
            n_entry.mask[k] = ({1'b0, sx} < i_cfg.eff_w) && ({1'b0, sy} < i_cfg.eff_h);
        end
    end

    // blocks with no pixel inside the frame are dropped here
    assign free       = !r_valid || (r_entry.mask == 4'd0) || !i_full;
    assign o_in_ready = free;
    assign o_push     = r_valid && (r_entry.mask != 4'd0) && !i_full;
    assign o_entry    = r_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (free) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (free && i_in_valid) begin
            r_entry <= n_entry;
        end
    end

endmodule

// ===== src/yrr_fifo.sv =====
module yrr_fifo import yrr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_blk i_data,
    output logic o_full,
    input  logic i_pop,
    output t_blk o_data,
    output logic o_empty
);

    localparam int PtrW = $clog2(QDEPTH);
    localparam int CntW = $clog2(QDEPTH + 1);

    t_blk            r_mem [QDEPTH];
    logic [PtrW-1:0] r_wr;
    logic [PtrW-1:0] r_rd;
    logic [CntW-1:0] r_cnt;

    assign o_full  = (r_cnt == CntW'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PtrW'(QDEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PtrW'(QDEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ===== src/yrr_back.sv =====
module yrr_back import yrr_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  t_blk     i_entry,
    input  logic     i_empty,
    output logic     o_pop,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_pix_out o_out_data
);

    t_blk                     r_cur;
    logic [3:0]               r_rem;

    logic                     r_a_valid;
    logic [27:0]              r_a_prod;
    logic [12:0]              r_a_x;
    logic signed [17:0]       r_a_c;
    logic signed [TERM_W-1:0] r_a_rt;
    logic signed [TERM_W-1:0] r_a_gt;
    logic signed [TERM_W-1:0] r_a_bt;
    logic                     r_a_last;

    logic                     r_o_valid;
    t_pix_out                 r_o_data;

    logic [1:0]               k;
    logic [3:0]               rem_next;
    logic                     last;
    logic [11:0]              sx;
    logic [11:0]              sy;
    logic [12:0]              x13;
    logic [12:0]              xm;
    logic [12:0]              ry;
    logic [12:0]              dw;
    logic [27:0]              prod;
    logic signed [17:0]       c;
    logic signed [18:0]       sr;
    logic signed [18:0]       sg;
    logic signed [18:0]       sb;
    logic                     b_adv;
    logic                     a_free;
    logic                     issue;
    logic                     take;
    t_pix_out                 n_o_data;

    // floor(s / 256) clamped to 0..255
    function automatic logic [7:0] to_chan(input logic signed [18:0] s);
        logic [7:0] res;
        if (s[18]) begin
            res = 8'd0;
        end else if (|s[17:16]) begin
            res = 8'hFF;
        end else begin
            res = s[15:8];
        end
        return res;
    endfunction

    always_comb begin
        if (r_rem[0]) begin
            k = 2'd0;
        end else if (r_rem[1]) begin
            k = 2'd1;
        end else if (r_rem[2]) begin
            k = 2'd2;
        end else begin
            k = 2'd3;
        end
        rem_next = r_rem & ~(4'b0001 << k);
        last     = (rem_next == 4'd0);
        sx = {r_cur.col[11:1], k[0]};
        sy = {r_cur.row[11:1], k[1]};

        case (i_cfg.rotation_mode)
            ROT_90: begin
                x13 = i_cfg.eff_h - 13'd1 - {1'b0, sy};
                ry  = {1'b0, sx};
                dw  = i_cfg.eff_h;
            end
            ROT_180: begin
                x13 = i_cfg.eff_w - 13'd1 - {1'b0, sx};
                ry  = i_cfg.eff_h - 13'd1 - {1'b0, sy};
                dw  = i_cfg.eff_w;
            end
            ROT_270: begin
                x13 = {1'b0, sy};
                ry  = i_cfg.eff_w - 13'd1 - {1'b0, sx};
                dw  = i_cfg.eff_h;
            end
            default: begin
                x13 = {1'b0, sx};
                ry  = {1'b0, sy};
                dw  = i_cfg.eff_w;
            end
        endcase
        xm   = i_cfg.mirror_enable ? (dw - 13'd1 - x13) : x13;
        prod = 28'(ry) * 28'(i_cfg.dest_row_bytes);
        c    = 18'sd298 * ($signed({1'b0, r_cur.luma[k]}) - 18'sd16);
    end

    always_comb begin
        sr = 19'(r_a_c) + 19'(r_a_rt);
        sg = 19'(r_a_c) + 19'(r_a_gt);
        sb = 19'(r_a_c) + 19'(r_a_bt);
        n_o_data.dest_offset = r_a_prod + {13'd0, r_a_x, 2'b00};
        n_o_data.red         = to_chan(sr);
        n_o_data.green       = to_chan(sg);
        n_o_data.blue        = to_chan(sb);
        n_o_data.last_pixel  = r_a_last;
    end

    assign b_adv  = !r_o_valid || i_out_ready;
    assign a_free = !r_a_valid || b_adv;
    assign issue  = a_free && (r_rem != 4'd0);
    // next block loads as the last pixel of the current one issues
    assign take   = !i_empty && ((r_rem == 4'd0) || (issue && last));
    assign o_pop  = take;

    assign o_out_valid = r_o_valid;
    assign o_out_data  = r_o_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem     <= 4'd0;
            r_a_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (take) begin
                r_rem <= i_entry.mask;
            end else if (issue) begin
                r_rem <= rem_next;
            end
            if (a_free) begin
                r_a_valid <= issue;
            end
            if (b_adv) begin
                r_o_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cur <= i_entry;
        end
        if (issue) begin
            r_a_prod <= prod;
            r_a_x    <= xm;
            r_a_c    <= c;
            r_a_rt   <= r_cur.r_term;
            r_a_gt   <= r_cur.g_term;
            r_a_bt   <= r_cur.b_term;
            r_a_last <= last;
        end
        if (b_adv && r_a_valid) begin
            r_o_data <= n_o_data;
        end
    end

endmodule

// ===== src/yuv420_to_rgba_rotate.sv =====
// YUV 4:2:0 to RGB converter with rotated/mirrored placement. Each input
// transaction is one 2x2 block; it yields one output transaction per block
// pixel inside the frame (raster order, last one flagged), with the byte offset
// of the pixel in the destination. Alpha is 255 and not carried. The pixel
// engine issues one pixel per clock while the output is not stalled and a block
// is queued; a block wholly outside the frame is dropped in the input stage and
// produces nothing. A 4-entry queue separates the input stage from the pixel
// engine. Frame sizes above MAX_DIM are treated as MAX_DIM. Write the
// registers only while no transaction is in flight.
module yuv420_to_rgba_rotate import yrr_pkg::*; #(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_blk_in     i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_pix_out    o_out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [14:0] MaxDim = 15'(MAX_DIM);

    logic [12:0] r_frame_width;
    logic [12:0] r_frame_height;
    logic [15:0] r_dest_row_bytes;
    logic [1:0]  r_rotation_mode;
    logic        r_mirror_enable;

    t_cfg        cfg;
    logic        wr_en;
    logic [2:0]  reg_idx;
    logic        push;
    logic        pop;
    logic        full;
    logic        empty;
    t_blk        q_in;
    t_blk        q_out;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width    <= 13'd640;
            r_frame_height   <= 13'd480;
            r_dest_row_bytes <= 16'd2560;
            r_rotation_mode  <= ROT_0;
            r_mirror_enable  <= 1'b0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_FRAME_WIDTH:    r_frame_width    <= pwdata[12:0];
                REG_FRAME_HEIGHT:   r_frame_height   <= pwdata[12:0];
                REG_DEST_ROW_BYTES: r_dest_row_bytes <= pwdata[15:0];
                REG_ROTATION_MODE:  r_rotation_mode  <= pwdata[1:0];
                REG_MIRROR_ENABLE:  r_mirror_enable  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_FRAME_WIDTH:    prdata = 32'(r_frame_width);
            REG_FRAME_HEIGHT:   prdata = 32'(r_frame_height);
            REG_DEST_ROW_BYTES: prdata = 32'(r_dest_row_bytes);
            REG_ROTATION_MODE:  prdata = 32'(r_rotation_mode);
            REG_MIRROR_ENABLE:  prdata = 32'(r_mirror_enable);
            default:            prdata = 32'd0;
        endcase
    end

    always_comb begin
        cfg.eff_w = ({2'b00, r_frame_width} > MaxDim) ? MaxDim[12:0] : r_frame_width;
        cfg.eff_h = ({2'b00, r_frame_height} > MaxDim) ? MaxDim[12:0] : r_frame_height;
        cfg.dest_row_bytes = r_dest_row_bytes;
        cfg.rotation_mode  = r_rotation_mode;
        cfg.mirror_enable  = r_mirror_enable;
    end

    yrr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_push     (push),
        .o_entry    (q_in),
        .i_full     (full)
    );

    yrr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (q_out),
        .o_empty (empty)
    );

    yrr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_entry     (q_out),
        .i_empty     (empty),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !full)
        else $error("block pushed into a full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !empty)
        else $error("block popped from an empty queue");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

endmodule

// ===== tb/sv/tb_yuv420_to_rgba_rotate.sv =====
`timescale 1ns / 1ps

module tb_yuv420_to_rgba_rotate;
    import yrr_pkg::*;

    localparam logic [2:0] REG_SPARE = 3'd5;   // decoded by paddr but not in the map
    localparam int STALL_LIMIT = 1000;
    localparam int DRAIN_CYCLES = 12;
    localparam int HOLD_CYCLES = 80;

    // one offered block; typed rows carry expected pixels that all share one level
    typedef struct packed {
        t_blk_in          blk;
        logic             typed;
        logic [2:0]       count;
        logic [3:0][27:0] offs;
        logic [7:0]       level;
    } t_blk_desc;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_blk_in     i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_pix_out    o_out_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // shadow copy of the register file
    logic [12:0] frame_w = 13'd640;
    logic [12:0] frame_h = 13'd480;
    logic [15:0] row_bytes = 16'd2560;
    logic [1:0]  rot_mode = ROT_0;
    logic        mirror = 1'b0;

    t_blk_desc directed_blocks[$];
    t_blk_desc offered_blocks[$];
    t_pix_out  pending_pixels[$];

    int  errors = 0;
    int  n_blocks = 0;
    int  n_pixels = 0;
    int  n_settings = 0;
    int  stall_cycles = 0;
    bit  quiet = 1'b0;
    int  hold_reqs = 0;
    int  hold_seen = 0;
    int  hold_left = 0;

    yuv420_to_rgba_rotate i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic int unsigned clamp_dim(input logic [12:0] v);
        return (v > MAX_DIM_DEF) ? MAX_DIM_DEF : int'(v);
    endfunction

    // floor(s / 256) clamped to a byte
    function automatic logic [7:0] to_channel(input int s);
        int q;
        q = s >>> 8;
        if (q < 0) return 8'd0;
        if (q > 255) return 8'd255;
        return q[7:0];
    endfunction

    function automatic t_blk_in mk_blk(input int col, input int row, input int tl, input int tr,
                                       input int bl, input int br, input int u, input int v);
        t_blk_in b;
        b.block_col = col[11:0];
        b.block_row = row[11:0];
        b.luma_top_left = tl[7:0];
        b.luma_top_right = tr[7:0];
        b.luma_bottom_left = bl[7:0];
        b.luma_bottom_right = br[7:0];
        b.chroma_u = u[7:0];
        b.chroma_v = v[7:0];
        return b;
    endfunction

    // converts one block under the shadow config and queues its pixels
    function automatic void convert_block(input t_blk_in b);
        int unsigned w, h, col, row, sx, sy, x, ry, dw, off;
        int          d, e, r_term, g_term, b_term, c, n, k;
        logic [7:0]  luma [4];
        t_pix_out    px [4];
        w = clamp_dim(frame_w);
        h = clamp_dim(frame_h);
        col = int'(b.block_col & 12'hFFE);
        row = int'(b.block_row & 12'hFFE);
        luma[0] = b.luma_top_left;
        luma[1] = b.luma_top_right;
        luma[2] = b.luma_bottom_left;
        luma[3] = b.luma_bottom_right;
        d = int'(b.chroma_u);
        d = d - 128;
        e = int'(b.chroma_v);
        e = e - 128;
        r_term = 409 * e + 128;
        g_term = -100 * d - 208 * e + 128;
        b_term = 516 * d + 128;
        n = 0;
        for (k = 0; k < 4; k++) begin
            sx = col + (k & 1);
            sy = row + (k >> 1);
            if (sx >= w || sy >= h) continue;
            c = int'(luma[k]);
            c = 298 * (c - 16);
            case (rot_mode)
                ROT_90: begin
                    x = h - 1 - sy; ry = sx; dw = h;
                end
                ROT_180: begin
                    x = w - 1 - sx; ry = h - 1 - sy; dw = w;
                end
                ROT_270: begin
                    x = sy; ry = w - 1 - sx; dw = h;
                end
                default: begin
                    x = sx; ry = sy; dw = w;
                end
            endcase
            if (mirror) x = dw - 1 - x;
            off = ry * row_bytes + x * 4;
            px[n].dest_offset = off[27:0];
            px[n].red = to_channel(c + r_term);
            px[n].green = to_channel(c + g_term);
            px[n].blue = to_channel(c + b_term);
            px[n].last_pixel = 1'b0;
            n++;
        end
        if (n > 0) px[n-1].last_pixel = 1'b1;
        for (k = 0; k < n; k++) pending_pixels.push_back(px[k]);
    endfunction

    // mostly blocks near or inside the frame, some anywhere
    function automatic t_blk_in rand_block();
        t_blk_in     b;
        int unsigned cl, rl;
        cl = clamp_dim(frame_w) + 1;
        rl = clamp_dim(frame_h) + 1;
        if (cl > 4095) cl = 4095;
        if (rl > 4095) rl = 4095;
        b.block_col = ($urandom_range(0, 99) < 15) ? 12'($urandom) : 12'($urandom_range(0, cl));
        b.block_row = ($urandom_range(0, 99) < 15) ? 12'($urandom) : 12'($urandom_range(0, rl));
        b.luma_top_left = 8'($urandom);
        b.luma_top_right = 8'($urandom);
        b.luma_bottom_left = 8'($urandom);
        b.luma_bottom_right = 8'($urandom);
        b.chroma_u = 8'($urandom);
        b.chroma_v = 8'($urandom);
        return b;
    endfunction

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        logic [31:0] rd_want;
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rd_want = '0;
        case (idx)
            REG_FRAME_WIDTH: begin
                frame_w = val[12:0];
                rd_want = 32'(val[12:0]);
            end
            REG_FRAME_HEIGHT: begin
                frame_h = val[12:0];
                rd_want = 32'(val[12:0]);
            end
            REG_DEST_ROW_BYTES: begin
                row_bytes = val[15:0];
                rd_want = 32'(val[15:0]);
            end
            REG_ROTATION_MODE: begin
                rot_mode = val[1:0];
                rd_want = 32'(val[1:0]);
            end
            REG_MIRROR_ENABLE: begin
                mirror = val[0];
                rd_want = 32'(val[0]);
            end
            default: ;
        endcase
        @(negedge i_clk);
        if (prdata !== rd_want) begin
            errors++;
            $display("%0t: register %0d read expected %h got %h", $time, idx, rd_want, prdata);
        end
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic send_block(input t_blk_desc item);
        int gap;
        gap = 0;
        while (!quiet && $urandom_range(0, 99) < 11) gap++;
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        offered_blocks.push_back(item);
        i_in_valid <= 1'b1;
        i_in_data <= item.blk;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // blocks wholly outside the frame leave nothing to wait on, so keep draining after the pixel queue empties
    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(input int w, input int h, input int rb, input logic [1:0] rot,
                             input logic mir, input int items, input bit hold, input bit calm);
        int i;
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
        write_reg(REG_DEST_ROW_BYTES, rb);
        write_reg(REG_ROTATION_MODE, 32'(rot));
        write_reg(REG_MIRROR_ENABLE, 32'(mir));
        n_settings++;
        quiet = calm;
        for (i = 0; i < items; i++) begin
            if (hold && i == 6) hold_reqs++;
            send_block('{rand_block(), 1'b0, 3'd0, '0, 8'd0});
        end
        wait_idle();
        quiet = 1'b0;
    endtask

    // receiver: random back-pressure plus one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_seen != hold_reqs) begin
            hold_seen <= hold_reqs;
            hold_left <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= quiet || ($urandom_range(0, 99) >= 11);
        end
    end

    always @(posedge i_clk) begin
        t_blk_desc cur;
        t_pix_out  want;
        bit        moved;
        int        k;
        moved = 1'b0;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                moved = 1'b1;
                n_blocks++;
                cur = offered_blocks.pop_front();
                if (cur.typed) begin
                    for (k = 0; k < cur.count; k++) begin
                        want.dest_offset = cur.offs[k];
                        want.red = cur.level;
                        want.green = cur.level;
                        want.blue = cur.level;
                        want.last_pixel = (k == cur.count - 1);
                        pending_pixels.push_back(want);
                    end
                end else begin
                    convert_block(cur.blk);
                end
            end
            if (o_out_valid && i_out_ready) begin
                moved = 1'b1;
                n_pixels++;
                if (pending_pixels.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected pixel transaction %h", $time, o_out_data);
                end else begin
                    want = pending_pixels.pop_front();
                    if (o_out_data.dest_offset !== want.dest_offset) begin
                        errors++;
                        $display("%0t: dest_offset expected %0d got %0d", $time,
                                 want.dest_offset, o_out_data.dest_offset);
                    end
                    if (o_out_data.red !== want.red) begin
                        errors++;
                        $display("%0t: red expected %0d got %0d", $time,
                                 want.red, o_out_data.red);
                    end
                    if (o_out_data.green !== want.green) begin
                        errors++;
                        $display("%0t: green expected %0d got %0d", $time,
                                 want.green, o_out_data.green);
                    end
                    if (o_out_data.blue !== want.blue) begin
                        errors++;
                        $display("%0t: blue expected %0d got %0d", $time,
                                 want.blue, o_out_data.blue);
                    end
                    if (o_out_data.last_pixel !== want.last_pixel) begin
                        errors++;
                        $display("%0t: last_pixel expected %0d got %0d", $time,
                                 want.last_pixel, o_out_data.last_pixel);
                    end
                end
            end
        end
        stall_cycles = moved ? 0 : stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no transaction for %0d cycles, %0d pixels outstanding", $time,
                     STALL_LIMIT, pending_pixels.size());
            $display("[yuv420_to_rgba_rotate] ERROR");
            $finish;
        end
    end

    initial begin
        int i;
        // reset config: 640x480, 2560-byte rows, no rotation
        directed_blocks.push_back('{mk_blk(0, 0, 16, 16, 16, 16, 128, 128), 1'b1, 3'd4,
                                    {28'd2564, 28'd2560, 28'd4, 28'd0}, 8'd0});
        directed_blocks.push_back('{mk_blk(0, 0, 255, 255, 255, 255, 128, 128), 1'b1, 3'd4,
                                    {28'd2564, 28'd2560, 28'd4, 28'd0}, 8'd255});
        // odd coordinates fold onto the even block
        directed_blocks.push_back('{mk_blk(1, 1, 16, 16, 16, 16, 128, 128), 1'b1, 3'd4,
                                    {28'd2564, 28'd2560, 28'd4, 28'd0}, 8'd0});
        directed_blocks.push_back('{mk_blk(638, 478, 16, 16, 16, 16, 128, 128), 1'b1, 3'd4,
                                    {28'd1228796, 28'd1228792, 28'd1226236, 28'd1226232},
                                    8'd0});
        directed_blocks.push_back('{mk_blk(639, 479, 255, 255, 255, 255, 128, 128), 1'b1, 3'd4,
                                    {28'd1228796, 28'd1228792, 28'd1226236, 28'd1226232},
                                    8'd255});
        // blocks wholly outside the frame
        directed_blocks.push_back('{mk_blk(640, 0, 200, 200, 200, 200, 50, 50), 1'b1, 3'd0,
                                    '0, 8'd0});
        directed_blocks.push_back('{mk_blk(0, 480, 200, 200, 200, 200, 50, 50), 1'b1, 3'd0,
                                    '0, 8'd0});
        directed_blocks.push_back('{mk_blk(4095, 4095, 255, 255, 255, 255, 255, 255), 1'b1,
                                    3'd0, '0, 8'd0});
        directed_blocks.push_back('{mk_blk(2, 2, 0, 255, 0, 255, 0, 0), 1'b0, 3'd0, '0, 8'd0});
        directed_blocks.push_back('{mk_blk(4, 4, 0, 0, 0, 0, 255, 255), 1'b0, 3'd0, '0, 8'd0});
        directed_blocks.push_back('{mk_blk(6, 8, 128, 128, 128, 128, 0, 255), 1'b0, 3'd0,
                                    '0, 8'd0});
        directed_blocks.push_back('{mk_blk(10, 12, 128, 128, 128, 128, 255, 0), 1'b0, 3'd0,
                                    '0, 8'd0});
        directed_blocks.push_back('{mk_blk(100, 200, 235, 16, 235, 16, 16, 240), 1'b0, 3'd0,
                                    '0, 8'd0});
        directed_blocks.push_back('{mk_blk(636, 2, 1, 2, 4, 8, 8'h55, 8'hAA), 1'b0, 3'd0,
                                    '0, 8'd0});
        directed_blocks.push_back('{mk_blk(12'h2AA, 12'h155, 8'hAA, 8'h55, 8'hF0, 8'h0F,
                                           8'hAA, 8'h55), 1'b0, 3'd0, '0, 8'd0});
        directed_blocks.push_back('{mk_blk(320, 240, 0, 0, 255, 255, 0, 0), 1'b0, 3'd0,
                                    '0, 8'd0});
        directed_blocks.push_back('{mk_blk(0, 478, 255, 0, 255, 0, 255, 255), 1'b0, 3'd0,
                                    '0, 8'd0});

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (i = 0; i < directed_blocks.size(); i++) send_block(directed_blocks[i]);
        wait_idle();

        // odd frame size gives partial edge blocks
        run_phase(7, 5, 4, ROT_90, 1'b0, 24, 1'b0, 1'b0);
        // largest legal frame and stride; long output hold-off fills the queue
        run_phase(4096, 4096, 65535, ROT_180, 1'b1, 30, 1'b1, 1'b0);
        // oversized frame clamps to the max; no idling on either side
        run_phase(8191, 6000, 20000, ROT_270, 1'b1, 24, 1'b0, 1'b1);
        // zero width: nothing comes out
        run_phase(0, 100, 2560, ROT_0, 1'b1, 6, 1'b0, 1'b0);
        write_reg(REG_SPARE, $urandom);
        run_phase(1, 1, 4, ROT_270, 1'b0, 10, 1'b0, 1'b0);
        run_phase(33, 17, 1000, ROT_90, 1'b1, 24, 1'b0, 1'b0);
        // zero height
        run_phase(640, 0, 2560, ROT_180, 1'b0, 4, 1'b0, 1'b0);
        run_phase($urandom_range(1, 300), $urandom_range(1, 300), $urandom_range(4, 65535),
                  ROT_0, 1'b1, 24, 1'b0, 1'b0);
        write_reg(REG_SPARE, 32'hFFFF_FFFF);
        run_phase(250, 3, 65535, ROT_180, 1'b0, 20, 1'b0, 1'b0);

        $display("covered %0d blocks, %0d pixels over %0d register settings", n_blocks,
                 n_pixels, n_settings + 1);
        $display("all four rotations with and without mirroring, edge, outside and empty frames");
        if (errors == 0) begin
            $display("[yuv420_to_rgba_rotate] OK");
        end else begin
            $display("[yuv420_to_rgba_rotate] ERROR");
        end
        $finish;
    end

endmodule
